FILE: rtl/tsac_pkg.sv
// shared types, codes and reset values for the turn signal auto-cancel block
`timescale 1ns / 1ps
package tsac_pkg;

  localparam int ThWidth    = 15;
  localparam int HoldWidth  = 20;
  localparam int TimeWidth  = 21;
  localparam int CfgWidth   = 20;
  localparam int CfgIdxWidth = 2;

  // command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_LEFT  = 2'd1;
  localparam logic [1:0] CMD_RIGHT = 2'd2;

  // stalk positions
  localparam logic [1:0] POS_OFF   = 2'd0;
  localparam logic [1:0] POS_LEFT  = 2'd1;
  localparam logic [1:0] POS_RIGHT = 2'd2;

  // cancel phases
  localparam logic [1:0] PH_INACTIVE = 2'd0;
  localparam logic [1:0] PH_TRAVEL   = 2'd1;
  localparam logic [1:0] PH_RETURN   = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxWidth-1:0] REG_TRAVEL   = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_RETURN   = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_OPPOSITE = 2'd2;
  localparam logic [CfgIdxWidth-1:0] REG_HOLD     = 2'd3;

  // reset values, q1.14 levels and microseconds
  localparam logic [ThWidth-1:0]   TRAVEL_RESET   = 15'd5407;
  localparam logic [ThWidth-1:0]   RETURN_RESET   = 15'd819;
  localparam logic [ThWidth-1:0]   OPPOSITE_RESET = 15'd8192;
  localparam logic [HoldWidth-1:0] HOLD_RESET     = 20'd500000;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] steering;
    logic [15:0]        elapsed_us;
  } in_item_t;

  typedef struct packed {
    logic [1:0] stalk_position;
    logic [1:0] cancel_phase;
    logic       cancelled_now;
  } out_item_t;

  typedef struct packed {
    logic [ThWidth-1:0]   travel_threshold;
    logic [ThWidth-1:0]   return_threshold;
    logic [ThWidth-1:0]   opposite_threshold;
    logic [HoldWidth-1:0] opposite_hold_us;
  } cfg_t;

endpackage

FILE: rtl/tsac_cfg_regs.sv
// configuration register file for the auto-cancel thresholds
`timescale 1ns / 1ps
module tsac_cfg_regs
  import tsac_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]    cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.travel_threshold   <= TRAVEL_RESET;
      cfg.return_threshold   <= RETURN_RESET;
      cfg.opposite_threshold <= OPPOSITE_RESET;
      cfg.opposite_hold_us   <= HOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRAVEL:   cfg.travel_threshold   <= cfg_data[ThWidth-1:0];
        REG_RETURN:   cfg.return_threshold   <= cfg_data[ThWidth-1:0];
        REG_OPPOSITE: cfg.opposite_threshold <= cfg_data[ThWidth-1:0];
        REG_HOLD:     cfg.opposite_hold_us   <= cfg_data[HoldWidth-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/tsac_core.sv
// stalk and cancel-phase state with its combinational next-state logic
`timescale 1ns / 1ps
module tsac_core
  import tsac_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  logic [1:0]           position_reg, position_next;
  logic [1:0]           phase_reg, phase_next;
  logic [TimeWidth-1:0] wrong_way_time, wrong_way_time_next;

  logic signed [16:0]   active, opp;
  logic [TimeWidth:0]   time_sum;
  logic [TimeWidth-1:0] time_sat;
  logic                 opp_over, expired, cancel;
  logic [1:0]           side, toggled;

  always_comb begin
    active   = (position_reg == POS_LEFT) ? 17'(item.steering) : -17'(item.steering);
    opp      = -active;
    opp_over = opp > $signed({2'b00, cfg.opposite_threshold});
    time_sum = {1'b0, wrong_way_time} + (TimeWidth+1)'(item.elapsed_us);
    time_sat = time_sum[TimeWidth] ? '1 : time_sum[TimeWidth-1:0];
    expired  = opp_over && (time_sat >= {1'b0, cfg.opposite_hold_us});
    side     = (item.command == CMD_LEFT) ? POS_LEFT : POS_RIGHT;
    toggled  = (position_reg == side) ? POS_OFF : side;

    position_next       = position_reg;
    phase_next          = phase_reg;
    wrong_way_time_next = wrong_way_time;
    cancel              = 1'b0;

    unique case (item.command)
      CMD_TICK: begin
        if (position_reg != POS_LEFT && position_reg != POS_RIGHT) begin
          position_next       = POS_OFF;
          phase_next          = PH_INACTIVE;
          wrong_way_time_next = '0;
        end else if (phase_reg == PH_TRAVEL || phase_reg == PH_RETURN) begin
          wrong_way_time_next = opp_over ? time_sat : '0;
          if (phase_reg == PH_TRAVEL) begin
            cancel = expired;
            if (!expired && active > $signed({2'b00, cfg.travel_threshold})) begin
              phase_next          = PH_RETURN;
              wrong_way_time_next = '0;
            end
          end else begin
            cancel = expired || (active < $signed({2'b00, cfg.return_threshold}));
          end
          if (cancel) begin
            position_next       = POS_OFF;
            phase_next          = PH_INACTIVE;
            wrong_way_time_next = '0;
          end
        end else begin
          // first tick after arming from inactive with the stalk on
          phase_next = PH_TRAVEL;
        end
      end
      CMD_LEFT, CMD_RIGHT: begin
        position_next       = toggled;
        wrong_way_time_next = '0;
        phase_next          = (toggled == side) ? PH_TRAVEL : PH_INACTIVE;
      end
      default: ;
    endcase

    result.stalk_position = position_next;
    result.cancel_phase   = phase_next;
    result.cancelled_now  = cancel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_reg   <= POS_OFF;
      phase_reg      <= PH_INACTIVE;
      wrong_way_time <= '0;
    end else if (advance) begin
      position_reg   <= position_next;
      phase_reg      <= phase_next;
      wrong_way_time <= wrong_way_time_next;
    end
  end

endmodule

FILE: rtl/turn_signal_auto_cancel_top.sv
// top level of the turn signal stalk with steering-based auto-cancel
`timescale 1ns / 1ps
// an accepted transaction waits in the input register, and its result then in the result register
// throughput: one transaction per cycle while out_stall is low
// an input register and a result register part the two channels
// reset (rst, synchronous): stalk off, phase inactive, hold timer zero,
//   thresholds back to their defaults, both pipeline slots empty
module turn_signal_auto_cancel_top
  import tsac_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_item,
  input  logic                   cfg_we,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]    cfg_data
);

  cfg_t      cfg;
  logic      in_held;       // input register occupied
  in_item_t  in_reg;
  out_item_t result;
  logic      out_free;      // result register can take a new result
  logic      advance;       // held transaction is processed this cycle
  logic      in_take;

  // threshold and hold-time registers
  tsac_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // result slot frees up when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;
  assign advance  = in_held && out_free;
  // input slot takes a new transaction when empty or moving on
  assign in_stall = in_held && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_take) begin
      in_held <= 1'b1;
    end else if (advance) begin
      in_held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_reg <= in_item;
    end
  end

  // stalk state and the whole per-transaction update
  tsac_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_reg),
    .cfg     (cfg),
    .result  (result)
  );

  // result register, holds while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

endmodule
